@@ hdl/quaternion_slerp_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion slerp core
// Same-cycle-implication and next-cycle-implication checks, reset aware.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_SLERP_CORE_MACROS_SVH
`define QUATERNION_SLERP_CORE_MACROS_SVH

// antecedent and consequent in the same cycle
`define QS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after the antecedent
`define QS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/qslerp_pkg.sv @@
// ----------------------------------------------------------------------------
// qslerp_pkg
// Shared constants, CORDIC word type and arctangent table for the slerp core.
// ----------------------------------------------------------------------------
`default_nettype none

package qslerp_pkg;

  localparam int CORDIC_STEPS = 30;
  // input register plus one stage per root bit
  localparam int SQRT_LAT     = 32;
  // input register plus one stage per CORDIC step
  localparam int SINE_LAT     = CORDIC_STEPS + 1;
  localparam int T_ONE        = 65536;

  // CORDIC datapath word, Q2.30 angles and vectors with headroom for gain
  typedef logic signed [33:0] cw_t;

  // atan(2^-i) in Q2.30, rounded to nearest
  localparam logic [29:0] ATAN_Q30 [CORDIC_STEPS] = '{
    30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159, 30'd67021687,
    30'd33543516,  30'd16775851,  30'd8388437,   30'd4194283,   30'd2097149,
    30'd1048576,   30'd524288,    30'd262144,    30'd131072,    30'd65536,
    30'd32768,     30'd16384,     30'd8192,      30'd4096,      30'd2048,
    30'd1024,      30'd512,       30'd256,       30'd128,       30'd64,
    30'd32,        30'd16,        30'd8,         30'd4,         30'd2
  };

endpackage

`default_nettype wire

@@ hdl/qslerp_isqrt.sv @@
// ----------------------------------------------------------------------------
// qslerp_isqrt
// Pipelined integer square root, floor(sqrt(v)) of a 62-bit value, one root
// bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [61:0] in_val,
  output logic        out_vld,
  output logic [30:0] out_root
);
  import qslerp_pkg::*;

  localparam int STEPS = SQRT_LAT - 1;

  logic [61:0] rem_r  [0:STEPS];
  logic [30:0] root_r [0:STEPS];
  logic        vld_r  [0:STEPS];

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r[0] <= 1'b0;
    else        vld_r[0] <= in_vld;
    rem_r[0]  <= in_val;
    root_r[0] <= '0;
  end

  // one stage per root bit, most significant first
  for (genvar g = 0; g < STEPS; g++) begin : g_bit
    localparam int K = STEPS - 1 - g;
    logic [63:0] trial;
    logic        take;
    assign trial = ({33'b0, root_r[g]} << (K + 1)) + (64'd1 << (2 * K));
    assign take  = ({2'b0, rem_r[g]} >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) vld_r[g+1] <= 1'b0;
      else        vld_r[g+1] <= vld_r[g];
      if (take) begin
        rem_r[g+1]  <= 62'({2'b0, rem_r[g]} - trial);
        root_r[g+1] <= root_r[g] | (31'd1 << K);
      end else begin
        rem_r[g+1]  <= rem_r[g];
        root_r[g+1] <= root_r[g];
      end
    end
  end

  assign out_vld  = vld_r[STEPS];
  assign out_root = root_r[STEPS];

endmodule

`default_nettype wire

@@ hdl/qslerp_sine.sv @@
// ----------------------------------------------------------------------------
// qslerp_sine
// Pipelined CORDIC rotation from (2^30, 0); returns the scaled sine of a
// nonnegative Q2.30 angle, one micro-rotation per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qslerp_sine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [30:0] in_phi,
  output logic        out_vld,
  output qslerp_pkg::cw_t out_sin
);
  import qslerp_pkg::*;

  cw_t  x_r [0:CORDIC_STEPS];
  cw_t  y_r [0:CORDIC_STEPS];
  cw_t  z_r [0:CORDIC_STEPS];
  logic v_r [0:CORDIC_STEPS];

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else        v_r[0] <= in_vld;
    x_r[0] <= cw_t'(34'sd1073741824);
    y_r[0] <= '0;
    z_r[0] <= cw_t'({3'b0, in_phi});
  end

  // micro-rotations
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_rot
    cw_t dx, dy, at;
    assign dx = y_r[g] >>> g;
    assign dy = x_r[g] >>> g;
    assign at = cw_t'({4'b0, ATAN_Q30[g]});

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[g+1] <= 1'b0;
      else        v_r[g+1] <= v_r[g];
      if (!z_r[g][33]) begin
        x_r[g+1] <= x_r[g] - dx;
        y_r[g+1] <= y_r[g] + dy;
        z_r[g+1] <= z_r[g] - at;
      end else begin
        x_r[g+1] <= x_r[g] + dx;
        y_r[g+1] <= y_r[g] - dy;
        z_r[g+1] <= z_r[g] + at;
      end
    end
  end

  assign out_vld = v_r[CORDIC_STEPS];
  assign out_sin = y_r[CORDIC_STEPS];

endmodule

`default_nettype wire

@@ hdl/quaternion_slerp_core.sv @@
// ----------------------------------------------------------------------------
// quaternion_slerp_core
// Shortest-path quaternion slerp in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_start_*, in_end_* (Q1.14) and in_fraction (Q1.16)
//   and raise start; the item is taken at every edge where start is high and
//   busy is low. busy stays low, so one item can enter on every clock.
//   Result channel: out_valid is high for one cycle with out_x..out_w (Q1.14,
//   normalized) and out_took_linear. There is no back-pressure; the receiver
//   must take each result in that cycle.
//   Throughput: one item per cycle. Most of the pipeline depth comes from two
//   31-stage square roots, a 30-stage vectoring CORDIC, a pair of 30-stage
//   rotation CORDICs and a 15-stage divider, each one step per stage.
//   Configuration: cfg_we with cfg_wdata writes near_threshold (Q1.14). Write
//   it only while no item is in flight.
//   Reset (rst_n low, synchronous) clears all valid bits, dropping items in
//   flight, and sets near_threshold to 16376.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_slerp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_start_x,
  input  logic signed [15:0] in_start_y,
  input  logic signed [15:0] in_start_z,
  input  logic signed [15:0] in_start_w,
  input  logic signed [15:0] in_end_x,
  input  logic signed [15:0] in_end_y,
  input  logic signed [15:0] in_end_z,
  input  logic signed [15:0] in_end_w,
  input  logic signed [17:0] in_fraction,
  input  logic               cfg_we,
  input  logic        [14:0] cfg_wdata,
  output logic               out_valid,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic signed [15:0] out_w,
  output logic               out_took_linear
);
  import qslerp_pkg::*;

  `include "quaternion_slerp_core_macros.svh"

  localparam logic [14:0] THR_RESET  = 15'd16376;
  localparam int          NORM_STEPS = 6;
  localparam int          DIV_STEPS  = 15;

  // geometry carried through the angle and weight stages
  typedef struct packed {
    logic [3:0][15:0] a;
    logic [3:0][16:0] b;
    logic [16:0]      t;
    logic             lin;
    logic             szero;
    logic [30:0]      d;
  } geo_t;

  typedef struct packed {
    logic [3:0][47:0] mag;
    logic [47:0]      m;
    logic [3:0]       sgn;
    logic             zero;
    logic             lin;
  } norm_t;

  typedef struct packed {
    logic [3:0][29:0] nm;
    logic [3:0]       sgn;
    logic             zero;
    logic             lin;
  } fin_t;

  typedef struct packed {
    logic [3:0][44:0] rem;
    logic [3:0][14:0] q;
    logic [30:0]      den;
    logic [3:0]       sgn;
    logic             zero;
    logic             lin;
  } div_t;

  // threshold register
  logic [14:0] thr_r;
  always_ff @(posedge clk) begin
    if (!rst_n)      thr_r <= THR_RESET;
    else if (cfg_we) thr_r <= cfg_wdata;
  end

  assign busy = 1'b0;

  // ---------------- stage A: capture, clamp fraction ----------------
  logic [16:0] t_clamp;
  always_comb begin
    if (in_fraction[17])                 t_clamp = '0;
    else if (in_fraction > 18'sd65536)   t_clamp = 17'(T_ONE);
    else                                 t_clamp = in_fraction[16:0];
  end

  geo_t geo_a_r;
  logic va_r;
  always_ff @(posedge clk) begin
    if (!rst_n) va_r <= 1'b0;
    else        va_r <= start;
    geo_a_r.a     <= {in_start_w, in_start_z, in_start_y, in_start_x};
    geo_a_r.b     <= {17'(in_end_w), 17'(in_end_z), 17'(in_end_y), 17'(in_end_x)};
    geo_a_r.t     <= t_clamp;
    geo_a_r.lin   <= 1'b0;
    geo_a_r.szero <= 1'b0;
    geo_a_r.d     <= '0;
  end

  // ---------------- stage B: component products ----------------
  logic signed [31:0] prod_r [4];
  geo_t geo_b_r;
  logic vb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vb_r <= 1'b0;
    else        vb_r <= va_r;
    geo_b_r <= geo_a_r;
    for (int i = 0; i < 4; i++) begin
      prod_r[i] <= 32'($signed(geo_a_r.a[i])) * 32'($signed(geo_a_r.b[i]));
    end
  end

  // ---------------- stage C: dot product, shortest path ----------------
  logic signed [33:0] dot;
  assign dot = 34'(prod_r[0]) + 34'(prod_r[1]) + 34'(prod_r[2]) + 34'(prod_r[3]);

  logic [32:0] dabs_r;
  geo_t geo_c_r;
  logic vc_r;
  always_ff @(posedge clk) begin : p_path
    geo_t g_c;
    if (!rst_n) vc_r <= 1'b0;
    else        vc_r <= vb_r;
    dabs_r <= dot[33] ? 33'(-dot) : dot[32:0];
    g_c = geo_b_r;
    if (dot[33]) begin
      for (int i = 0; i < 4; i++) begin
        g_c.b[i] = 17'(-$signed(geo_b_r.b[i]));
      end
    end
    geo_c_r <= g_c;
  end

  // ---------------- stage D: threshold test, clamp to 1.0 ----------------
  logic [28:0] dclamp;
  assign dclamp = (dabs_r > 33'd268435456) ? 29'd268435456 : dabs_r[28:0];

  geo_t geo_d_r;
  logic vd_r;
  always_ff @(posedge clk) begin : p_thr
    geo_t g_d;
    if (!rst_n) vd_r <= 1'b0;
    else        vd_r <= vc_r;
    g_d     = geo_c_r;
    g_d.lin = (dabs_r > {4'b0, thr_r, 14'b0});
    g_d.d   = {dclamp, 2'b00};
    geo_d_r <= g_d;
  end

  // ---------------- stage E: 1 - d^2 ----------------
  logic [61:0] sq_r;
  geo_t geo_e_r;
  logic ve_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ve_r <= 1'b0;
    else        ve_r <= vd_r;
    sq_r    <= (62'd1 << 60) - (62'(geo_d_r.d) * 62'(geo_d_r.d));
    geo_e_r <= geo_d_r;
  end

  // ---------------- sin(theta) by square root ----------------
  logic        r1_vld;
  logic [30:0] r1_root;
  qslerp_isqrt u_sqrt_sin (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (ve_r),
    .in_val   (sq_r),
    .out_vld  (r1_vld),
    .out_root (r1_root)
  );

  geo_t dl1_r [SQRT_LAT];
  always_ff @(posedge clk) begin
    dl1_r[0] <= geo_e_r;
    for (int i = 1; i < SQRT_LAT; i++) dl1_r[i] <= dl1_r[i-1];
  end

  // ---------------- theta by vectoring CORDIC ----------------
  cw_t  vx_r [0:CORDIC_STEPS];
  cw_t  vy_r [0:CORDIC_STEPS];
  cw_t  vz_r [0:CORDIC_STEPS];
  geo_t vg_r [0:CORDIC_STEPS];
  logic vv_r [0:CORDIC_STEPS];

  always_ff @(posedge clk) begin : p_vec_in
    geo_t g_v;
    if (!rst_n) vv_r[0] <= 1'b0;
    else        vv_r[0] <= r1_vld;
    vx_r[0]   <= cw_t'({3'b0, dl1_r[SQRT_LAT-1].d});
    vy_r[0]   <= cw_t'({3'b0, r1_root});
    vz_r[0]   <= '0;
    g_v       = dl1_r[SQRT_LAT-1];
    g_v.szero = (r1_root == '0);
    vg_r[0]   <= g_v;
  end

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_vec
    cw_t dx, dy, at;
    assign dx = vy_r[g] >>> g;
    assign dy = vx_r[g] >>> g;
    assign at = cw_t'({4'b0, ATAN_Q30[g]});

    always_ff @(posedge clk) begin
      if (!rst_n) vv_r[g+1] <= 1'b0;
      else        vv_r[g+1] <= vv_r[g];
      vg_r[g+1] <= vg_r[g];
      if (!vy_r[g][33]) begin
        vx_r[g+1] <= vx_r[g] + dx;
        vy_r[g+1] <= vy_r[g] - dy;
        vz_r[g+1] <= vz_r[g] + at;
      end else begin
        vx_r[g+1] <= vx_r[g] - dx;
        vy_r[g+1] <= vy_r[g] + dy;
        vz_r[g+1] <= vz_r[g] - at;
      end
    end
  end

  // ---------------- stage P: split angle by t ----------------
  geo_t        geo_v;
  logic [30:0] theta;
  logic [16:0] t_rest;
  logic [47:0] pha_full, phb_full;
  assign geo_v    = vg_r[CORDIC_STEPS];
  assign theta    = vz_r[CORDIC_STEPS][33] ? '0 : vz_r[CORDIC_STEPS][30:0];
  assign t_rest   = 17'(T_ONE) - geo_v.t;
  assign phb_full = 48'(theta) * 48'(geo_v.t);
  assign pha_full = 48'(theta) * 48'(t_rest);

  logic [30:0] pha_r, phb_r;
  geo_t geo_p_r;
  logic vp_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vp_r <= 1'b0;
    else        vp_r <= vv_r[CORDIC_STEPS];
    pha_r   <= pha_full[46:16];
    phb_r   <= phb_full[46:16];
    geo_p_r <= geo_v;
  end

  // ---------------- sine weights ----------------
  logic sa_vld, sb_vld;
  cw_t  sa_sin, sb_sin;
  qslerp_sine u_sine_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vp_r),
    .in_phi  (pha_r),
    .out_vld (sa_vld),
    .out_sin (sa_sin)
  );
  qslerp_sine u_sine_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vp_r),
    .in_phi  (phb_r),
    .out_vld (sb_vld),
    .out_sin (sb_sin)
  );

  geo_t dl2_r [SINE_LAT];
  always_ff @(posedge clk) begin
    dl2_r[0] <= geo_p_r;
    for (int i = 1; i < SINE_LAT; i++) dl2_r[i] <= dl2_r[i-1];
  end

  // ---------------- stage M: weight select, weighted products ----------------
  geo_t geo_s;
  cw_t  wa, wb;
  assign geo_s = dl2_r[SINE_LAT-1];
  always_comb begin
    if (geo_s.lin || geo_s.szero) begin
      wa = cw_t'({17'b0, 17'(17'(T_ONE) - geo_s.t)});
      wb = cw_t'({17'b0, geo_s.t});
    end else begin
      wa = sa_sin;
      wb = sb_sin;
    end
  end

  logic signed [47:0] pa_r [4];
  logic signed [47:0] pb_r [4];
  logic lin_m_r;
  logic vm_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vm_r <= 1'b0;
    else        vm_r <= sa_vld & sb_vld;
    lin_m_r <= geo_s.lin;
    for (int i = 0; i < 4; i++) begin
      pa_r[i] <= 48'(wa) * 48'($signed(geo_s.a[i]));
      pb_r[i] <= 48'(wb) * 48'($signed(geo_s.b[i]));
    end
  end

  // ---------------- stage N: sum, magnitude and sign ----------------
  logic [3:0][47:0] mag_r;
  logic [3:0]       sgn_r;
  logic             lin_n_r;
  logic             vn_r;
  always_ff @(posedge clk) begin : p_sum
    logic signed [48:0] v;
    if (!rst_n) vn_r <= 1'b0;
    else        vn_r <= vm_r;
    lin_n_r <= lin_m_r;
    for (int i = 0; i < 4; i++) begin
      v        = 49'(pa_r[i]) + 49'(pb_r[i]);
      sgn_r[i] <= v[48];
      mag_r[i] <= v[48] ? 48'(-v) : v[47:0];
    end
  end

  // ---------------- stage X1: pairwise maximum ----------------
  logic [47:0]      m01_r, m23_r;
  logic [3:0][47:0] mag_x_r;
  logic [3:0]       sgn_x_r;
  logic             lin_x_r;
  logic             vx1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vx1_r <= 1'b0;
    else        vx1_r <= vn_r;
    m01_r   <= (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
    m23_r   <= (mag_r[2] > mag_r[3]) ? mag_r[2] : mag_r[3];
    mag_x_r <= mag_r;
    sgn_x_r <= sgn_r;
    lin_x_r <= lin_n_r;
  end

  // ---------------- stage X2: overall maximum ----------------
  norm_t nrm_r [0:NORM_STEPS];
  logic  nv_r  [0:NORM_STEPS];
  logic [47:0] m_max;
  assign m_max = (m01_r > m23_r) ? m01_r : m23_r;

  always_ff @(posedge clk) begin
    if (!rst_n) nv_r[0] <= 1'b0;
    else        nv_r[0] <= vx1_r;
    nrm_r[0].mag  <= mag_x_r;
    nrm_r[0].m    <= m_max;
    nrm_r[0].sgn  <= sgn_x_r;
    nrm_r[0].zero <= (m_max == '0);
    nrm_r[0].lin  <= lin_x_r;
  end

  // ---------------- normalize: leading one of the max to bit 47 ----------------
  for (genvar g = 0; g < NORM_STEPS; g++) begin : g_norm
    localparam int SH = 32 >> g;
    logic top_zero;
    assign top_zero = (nrm_r[g].m[47 -: SH] == '0);

    always_ff @(posedge clk) begin : p_shift
      norm_t nx;
      if (!rst_n) nv_r[g+1] <= 1'b0;
      else        nv_r[g+1] <= nv_r[g];
      nx = nrm_r[g];
      if (top_zero) begin
        nx.m = nrm_r[g].m << SH;
        for (int i = 0; i < 4; i++) begin
          nx.mag[i] = nrm_r[g].mag[i] << SH;
        end
      end
      nrm_r[g+1] <= nx;
    end
  end

  // ---------------- stage R: scale to [2^29, 2^30), squares ----------------
  norm_t nrm_o;
  assign nrm_o = nrm_r[NORM_STEPS];

  logic [59:0] sqm_r [4];
  fin_t fin_r_r;
  logic vr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vr_r <= 1'b0;
    else        vr_r <= nv_r[NORM_STEPS];
    for (int i = 0; i < 4; i++) begin
      fin_r_r.nm[i] <= nrm_o.mag[i][47:18];
      sqm_r[i]      <= 60'(nrm_o.mag[i][47:18]) * 60'(nrm_o.mag[i][47:18]);
    end
    fin_r_r.sgn  <= nrm_o.sgn;
    fin_r_r.zero <= nrm_o.zero;
    fin_r_r.lin  <= nrm_o.lin;
  end

  // ---------------- stage S: sum of squares ----------------
  logic [61:0] ssum_r;
  fin_t fin_s_r;
  logic vs_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vs_r <= 1'b0;
    else        vs_r <= vr_r;
    ssum_r  <= 62'(sqm_r[0]) + 62'(sqm_r[1]) + 62'(sqm_r[2]) + 62'(sqm_r[3]);
    fin_s_r <= fin_r_r;
  end

  // ---------------- norm by square root ----------------
  logic        r2_vld;
  logic [30:0] r2_root;
  qslerp_isqrt u_sqrt_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vs_r),
    .in_val   (ssum_r),
    .out_vld  (r2_vld),
    .out_root (r2_root)
  );

  fin_t dl3_r [SQRT_LAT];
  always_ff @(posedge clk) begin
    dl3_r[0] <= fin_s_r;
    for (int i = 1; i < SQRT_LAT; i++) dl3_r[i] <= dl3_r[i-1];
  end

  // ---------------- stage U: rounded numerators ----------------
  fin_t fin_u;
  assign fin_u = dl3_r[SQRT_LAT-1];

  div_t dv_r  [0:DIV_STEPS];
  logic dvv_r [0:DIV_STEPS];
  always_ff @(posedge clk) begin
    if (!rst_n) dvv_r[0] <= 1'b0;
    else        dvv_r[0] <= r2_vld;
    for (int i = 0; i < 4; i++) begin
      dv_r[0].rem[i] <= 45'({fin_u.nm[i], 14'b0}) + 45'(r2_root[30:1]);
    end
    dv_r[0].q    <= '0;
    dv_r[0].den  <= r2_root;
    dv_r[0].sgn  <= fin_u.sgn;
    dv_r[0].zero <= fin_u.zero;
    dv_r[0].lin  <= fin_u.lin;
  end

  // ---------------- restoring divide, one quotient bit per stage ----------------
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    localparam int K = DIV_STEPS - 1 - g;
    logic [45:0] trial;
    assign trial = 46'(dv_r[g].den) << K;

    always_ff @(posedge clk) begin : p_step
      div_t nx;
      if (!rst_n) dvv_r[g+1] <= 1'b0;
      else        dvv_r[g+1] <= dvv_r[g];
      nx = dv_r[g];
      for (int i = 0; i < 4; i++) begin
        if ({1'b0, dv_r[g].rem[i]} >= trial) begin
          nx.rem[i]  = 45'({1'b0, dv_r[g].rem[i]} - trial);
          nx.q[i][K] = 1'b1;
        end
      end
      dv_r[g+1] <= nx;
    end
  end

  // ---------------- stage O: saturate, restore sign ----------------
  div_t dv_o;
  assign dv_o = dv_r[DIV_STEPS];

  logic [15:0] oc_r [4];
  logic        olin_r;
  logic        ov_r;
  always_ff @(posedge clk) begin : p_out
    logic [14:0] qs;
    if (!rst_n) ov_r <= 1'b0;
    else        ov_r <= dvv_r[DIV_STEPS];
    olin_r <= dv_o.lin;
    for (int i = 0; i < 4; i++) begin
      qs = (dv_o.q[i] > 15'd16384) ? 15'd16384 : dv_o.q[i];
      if (dv_o.zero)       oc_r[i] <= '0;
      else if (dv_o.sgn[i]) oc_r[i] <= 16'(-{1'b0, qs});
      else                 oc_r[i] <= {1'b0, qs};
    end
  end

  assign out_valid       = ov_r;
  assign out_x           = oc_r[0];
  assign out_y           = oc_r[1];
  assign out_z           = oc_r[2];
  assign out_w           = oc_r[3];
  assign out_took_linear = olin_r;

  // ---------------- checks ----------------
  `QS_ASSERT_IMPL(a_sine_align, clk, rst_n, 1'b1, sa_vld == sb_vld, "sine lanes out of step")
  `QS_ASSERT_IMPL(a_norm_msb, clk, rst_n, nv_r[NORM_STEPS] && !nrm_o.zero, nrm_o.m[47], "normalizer left max unaligned")
  `QS_ASSERT_IMPL(a_norm_root, clk, rst_n, r2_vld && !fin_u.zero, r2_root[30:29] != 2'b00, "norm root below range")
  `QS_ASSERT_IMPL(a_quot_range, clk, rst_n, dvv_r[DIV_STEPS] && !dv_o.zero, (dv_o.q[0] <= 15'd16384) && (dv_o.q[1] <= 15'd16384) && (dv_o.q[2] <= 15'd16384) && (dv_o.q[3] <= 15'd16384), "quotient above one")
  `QS_ASSERT_NEXT(a_out_range, clk, rst_n, dvv_r[DIV_STEPS], out_valid && (out_x <= 16'sd16384) && (out_x >= -16'sd16384) && (out_w <= 16'sd16384) && (out_w >= -16'sd16384), "result strobe or range wrong")

endmodule

`default_nettype wire

@@ verif/tb_quaternion_slerp_core.sv @@
// ----------------------------------------------------------------------------
// tb_quaternion_slerp_core
// Self-checking bench for the slerp core. A short directed table is followed
// by random unit, near-duplicate and out-of-range quaternion items, run under
// several near_threshold settings. Results are checked against a local
// fixed-point model of the slerp datapath, or against pinned directed values.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quaternion_slerp_core;
  timeunit 1ns;
  timeprecision 1ps;

  import qslerp_pkg::*;

  localparam int LATENCY = 160;

  typedef struct packed {
    logic [3:0][15:0] s;
    logic [3:0][15:0] e;
    logic [17:0]      f;
  } slerp_item_t;

  typedef struct packed {
    logic [3:0][15:0] q;
    logic             lin;
  } slerp_res_t;

  typedef struct {
    int  s[4];
    int  e[4];
    int  f;
    bit  pinned;
    int  q[4];
    bit  lin;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_start_x = '0, in_start_y = '0, in_start_z = '0, in_start_w = '0;
  logic signed [15:0] in_end_x = '0, in_end_y = '0, in_end_z = '0, in_end_w = '0;
  logic signed [17:0] in_fraction = '0;
  logic        cfg_we = 1'b0;
  logic [14:0] cfg_wdata = '0;
  logic        out_valid;
  logic signed [15:0] out_x, out_y, out_z, out_w;
  logic        out_took_linear;

  slerp_res_t  expected_results[$];
  slerp_res_t  pinned_results[$];
  bit          pinned_flags[$];
  logic [14:0] model_threshold = 15'd16376;
  int          errors = 0;
  int          n_items = 0;
  int          n_checked = 0;
  int          n_linear = 0;
  int          n_cfg = 0;

  always #6 clk = ~clk;

  quaternion_slerp_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_start_z(in_start_z), .in_start_w(in_start_w),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .in_end_z(in_end_z), .in_end_w(in_end_w),
    .in_fraction(in_fraction),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .out_w(out_w), .out_took_linear(out_took_linear)
  );

  // --------------------------------------------------------------------------
  // fixed-point slerp model
  // --------------------------------------------------------------------------
  function automatic longint unsigned isqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // vectoring: angle of (x, y)
  function automatic longint cordic_vec(input longint x, input longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_Q30[i]);
      end else begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_Q30[i]);
      end
    end
    return z;
  endfunction

  // rotation from (1, 0): scaled sine of z
  function automatic longint cordic_sin(input longint z);
    longint x, y, dx, dy;
    x = longint'(1) << 30;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - longint'(ATAN_Q30[i]);
      end else begin
        x = x + dx; y = y - dy; z = z + longint'(ATAN_Q30[i]);
      end
    end
    return y;
  endfunction

  function automatic slerp_res_t slerp_predict(input slerp_item_t it, input logic [14:0] thr);
    longint a[4], b[4], v[4];
    longint t, dot, wa, wb, d, s, theta;
    longint unsigned mag[4], m, sum, n, q;
    slerp_res_t r;
    r = '0;
    dot = 0;
    m = 0;
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      a[i] = longint'($signed(it.s[i]));
      b[i] = longint'($signed(it.e[i]));
      dot = dot + a[i] * b[i];
    end
    t = longint'($signed(it.f));
    if (t < 0) t = 0;
    if (t > T_ONE) t = T_ONE;
    // shortest path: flip the end quaternion
    if (dot < 0) begin
      for (int i = 0; i < 4; i++) b[i] = -b[i];
      dot = -dot;
    end
    wa = T_ONE - t;
    wb = t;
    if (dot > longint'(thr) * 16384) begin
      r.lin = 1'b1;
    end else begin
      d = (dot > (longint'(1) << 28)) ? (longint'(1) << 28) : dot;
      d = d * 4;
      s = longint'(isqrt((64'd1 << 60) - longint'(d * d)));
      // zero angle keeps the linear weights
      if (s != 0) begin
        theta = cordic_vec(d, s);
        if (theta < 0) theta = 0;
        wb = cordic_sin((theta * t) >>> 16);
        wa = cordic_sin((theta * (T_ONE - t)) >>> 16);
      end
    end
    for (int i = 0; i < 4; i++) begin
      v[i] = wa * a[i] + wb * b[i];
      mag[i] = (v[i] < 0) ? -v[i] : v[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) return r;
    while (m >= (64'd1 << 30)) begin
      for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 1;
      m = m >> 1;
    end
    while (m < (64'd1 << 29)) begin
      for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
      m = m << 1;
    end
    for (int i = 0; i < 4; i++) sum = sum + mag[i] * mag[i];
    n = isqrt(sum);
    for (int i = 0; i < 4; i++) begin
      q = (mag[i] * 16384 + n / 2) / n;
      if (q > 16384) q = 16384;
      r.q[i] = (v[i] < 0) ? -q[15:0] : q[15:0];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // accept monitor: predict each item and track threshold writes
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    slerp_item_t it;
    slerp_res_t  pin;
    slerp_res_t  exp_item;
    bit          use_pin;
    if (rst_n && cfg_we) model_threshold <= cfg_wdata;
    if (rst_n && start && !busy) begin
      it.s = {in_start_w, in_start_z, in_start_y, in_start_x};
      it.e = {in_end_w, in_end_z, in_end_y, in_end_x};
      it.f = in_fraction;
      use_pin = 1'b0;
      pin = '0;
      if (pinned_flags.size() > 0) begin
        use_pin = pinned_flags.pop_front();
        pin = pinned_results.pop_front();
      end
      exp_item = use_pin ? pin : slerp_predict(it, model_threshold);
      expected_results = {expected_results, exp_item};
      n_items++;
    end
  end

  // --------------------------------------------------------------------------
  // result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    slerp_res_t exp_r;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no item pending: %h %h %h %h lin=%b", $realtime,
                 out_x, out_y, out_z, out_w, out_took_linear);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        n_checked++;
        if (out_took_linear) n_linear++;
        if ({out_w, out_z, out_y, out_x} !== exp_r.q || out_took_linear !== exp_r.lin) begin
          $display("%0t: mismatch exp x=%0d y=%0d z=%0d w=%0d lin=%b", $realtime,
                   $signed(exp_r.q[0]), $signed(exp_r.q[1]), $signed(exp_r.q[2]),
                   $signed(exp_r.q[3]), exp_r.lin);
          $display("%0t:          got x=%0d y=%0d z=%0d w=%0d lin=%b", $realtime,
                   out_x, out_y, out_z, out_w, out_took_linear);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  int burst_left = 0;

  task automatic send_item(input int s[4], input int e[4], input int f,
                           input bit pinned, input slerp_res_t pin);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 8));
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    pinned_flags = {pinned_flags, pinned};
    pinned_results = {pinned_results, pin};
    in_start_x <= 16'(s[0]); in_start_y <= 16'(s[1]);
    in_start_z <= 16'(s[2]); in_start_w <= 16'(s[3]);
    in_end_x <= 16'(e[0]); in_end_y <= 16'(e[1]);
    in_end_z <= 16'(e[2]); in_end_w <= 16'(e[3]);
    in_fraction <= 18'(f);
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // threshold write with the pipe drained
  task automatic write_threshold(input logic [14:0] val);
    start <= 1'b0;
    burst_left = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  task automatic unit_quat(output int q[4]);
    real c[4], nrm;
    nrm = 0.0;
    for (int i = 0; i < 4; i++) begin
      c[i] = real'(int'($urandom_range(0, 65535)) - 32768);
      nrm += c[i] * c[i];
    end
    if (nrm == 0.0) begin
      c[0] = 1.0;
      nrm = 1.0;
    end
    nrm = $sqrt(nrm);
    for (int i = 0; i < 4; i++) q[i] = $rtoi(c[i] / nrm * 16384.0);
  endtask

  task automatic random_item();
    int s[4], e[4], f, kind;
    kind = $urandom_range(0, 9);
    unit_quat(s);
    if (kind == 0) begin
      // raw noise over the whole port width
      for (int i = 0; i < 4; i++) begin
        s[i] = int'($signed(16'($urandom)));
        e[i] = int'($signed(16'($urandom)));
      end
    end else if (kind <= 3) begin
      // near-duplicate end, sometimes on the far hemisphere
      for (int i = 0; i < 4; i++) begin
        e[i] = s[i] + int'($urandom_range(0, 2 * (1 << (kind * 3)))) - (1 << (kind * 3));
        if (kind == 3) e[i] = -e[i];
      end
    end else begin
      unit_quat(e);
    end
    case ($urandom_range(0, 9))
      0:       f = int'($signed(18'($urandom)));
      1:       f = 0;
      2:       f = T_ONE;
      default: f = $urandom_range(0, T_ONE);
    endcase
    send_item(s, e, f, 1'b0, '0);
  endtask

  table_row_t dir_rows[$];

  function automatic table_row_t row(input int sx, sy, sz, sw, ex, ey, ez, ew, f,
                                     input bit pinned = 0, input int qx = 0, qy = 0,
                                     qz = 0, qw = 0, input bit lin = 0);
    table_row_t r;
    r.s = '{sx, sy, sz, sw};
    r.e = '{ex, ey, ez, ew};
    r.f = f;
    r.pinned = pinned;
    r.q = '{qx, qy, qz, qw};
    r.lin = lin;
    return r;
  endfunction

  initial begin
    slerp_res_t pin;
    logic [14:0] thr_list[6];
    dir_rows = {dir_rows, row(16384, 0, 0, 0, 16384, 0, 0, 0, 0, 1, 16384, 0, 0, 0, 1)};
    dir_rows = {dir_rows, row(16384, 0, 0, 0, 16384, 0, 0, 0, T_ONE, 1, 16384, 0, 0, 0, 1)};
    dir_rows = {dir_rows, row(16384, 0, 0, 0, -16384, 0, 0, 0, 32768, 1, 16384, 0, 0, 0, 1)};
    dir_rows = {dir_rows, row(0, 0, 0, 0, 0, 0, 0, 0, 32768, 1, 0, 0, 0, 0, 0)};
    dir_rows = {dir_rows, row(0, 0, 0, -16384, 0, 0, 0, -16384, -131072, 1, 0, 0, 0, -16384, 1)};
    dir_rows = {dir_rows, row(0, 16384, 0, 0, 0, 16384, 0, 0, 131071, 1, 0, 16384, 0, 0, 1)};
    dir_rows = {dir_rows, row(16384, 0, 0, 0, 0, 16384, 0, 0, 0)};
    dir_rows = {dir_rows, row(16384, 0, 0, 0, 0, 16384, 0, 0, 32768)};
    dir_rows = {dir_rows, row(16384, 0, 0, 0, 0, 16384, 0, 0, T_ONE)};
    dir_rows = {dir_rows, row(16384, 0, 0, 0, 0, -16384, 0, 0, 16384)};
    dir_rows = {dir_rows, row(8192, 8192, 8192, 8192, -8192, 8192, 8192, 8192, 49152)};
    dir_rows = {dir_rows, row(16384, 0, 0, 0, 16383, 181, 0, 0, 32768)};
    dir_rows = {dir_rows, row(16384, 0, 0, 0, 16300, 1650, 0, 0, 32768)};
    dir_rows = {dir_rows, row(-32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767,
                              20000)};
    dir_rows = {dir_rows, row(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 40000)};
    dir_rows = {dir_rows, row(-32768, 32767, 0, -1, 1, -16384, 16384, -32768, 65537)};
    dir_rows = {dir_rows, row(16384, 0, 0, 0, 0, 0, 0, 0, 32768)};
    dir_rows = {dir_rows, row(5, 0, 0, 0, 0, 3, 0, 0, -1)};

    thr_list = '{15'd0, 15'd16384, 15'h7FFF, 15'd16200, 15'd16376, 15'd0};
    thr_list[3] = 15'($urandom_range(15000, 16383));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at the reset threshold
    foreach (dir_rows[i]) begin
      pin.q = {16'(dir_rows[i].q[3]), 16'(dir_rows[i].q[2]),
               16'(dir_rows[i].q[1]), 16'(dir_rows[i].q[0])};
      pin.lin = dir_rows[i].lin;
      send_item(dir_rows[i].s, dir_rows[i].e, dir_rows[i].f, dir_rows[i].pinned, pin);
    end

    // random phases, one threshold each; zero-angle slerp shows up at 16384 and above
    foreach (thr_list[p]) begin
      write_threshold(thr_list[p]);
      if (thr_list[p] >= 15'd16384) begin
        foreach (dir_rows[i]) begin
          if (i < 6) send_item(dir_rows[i].s, dir_rows[i].e, dir_rows[i].f, 1'b0, '0);
        end
      end
      repeat (300) random_item();
    end
    start <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 40) @(posedge clk);
    $display("%0d items sent, %0d results checked (%0d linear), %0d threshold writes",
             n_items, n_checked, n_linear, n_cfg);
    if (errors == 0 && expected_results.size() == 0)
      $display("tb_quaternion_slerp_core OK");
    else
      $display("tb_quaternion_slerp_core NOT OK");
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("tb_quaternion_slerp_core NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+hdl
hdl/qslerp_pkg.sv
hdl/qslerp_isqrt.sv
hdl/qslerp_sine.sv
hdl/quaternion_slerp_core.sv
verif/tb_quaternion_slerp_core.sv
